[hw/rtl/pat_pkg.sv]
// Package with the shared types and constants of the per-AS traffic counter.
package pat_pkg;

  localparam int unsigned AsW    = 16;
  localparam int unsigned LenW   = 16;
  localparam int unsigned SecW   = 32;
  localparam int unsigned CntW   = 64;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 176;

  localparam logic KindPacket = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef enum logic [5:0] {
    ST_CLR   = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_PKT_S = 6'b000100,
    ST_PKT_D = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

endpackage

[hw/rtl/per_as_traffic_top_k.sv]
// Per-AS byte and packet counter with a ranked top-K report that clears the table.
// A packet reads and writes back the source entry, then the destination
// entry, through the simple dual-port counter memory (one read and one write per cycle).
// A report scans all AS_ENTRIES entries, one per cycle,
// zeroing each, then sends one record per beat as the output side takes them.
// After reset a clearing pass zeroes the memory; no item is taken during it.
module per_as_traffic_top_k
  import pat_pkg::*;
#(
  parameter int unsigned AS_ENTRIES = 65536,
  parameter int unsigned TOP_COUNT  = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // src_as[15:0], dst_as[31:16], ip_length[47:32], time_sec[79:48]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // kind
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // interval_start[31:0], as_number[47:32], byte_total[111:48], packet_total[175:112]
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // has_entry
  output logic                m_axis_tuser_o,
  output logic                m_axis_tlast_o
);

  localparam int unsigned AW = $clog2(AS_ENTRIES);
  localparam int unsigned CW = $clog2(TOP_COUNT + 1);
  localparam int unsigned TW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
  localparam int unsigned MW = 2 * CntW;

  // The table index is the AS number modulo AS_ENTRIES, taken by a reciprocal
  // multiplication that is exact for every 16-bit AS number.
  localparam longint unsigned RecipL =
      ((64'd1 << 32) + 64'(AS_ENTRIES) - 64'd1) / 64'(AS_ENTRIES);
  localparam logic [24:0] Recip = 25'(RecipL);

  function automatic logic [AW-1:0] slot_of(input logic [AsW-1:0] as_num);
    logic [40:0] prod;
    logic [8:0]  quo;
    logic [24:0] back;
    prod = 41'(as_num) * 41'(Recip);
    quo  = prod[40:32];
    back = 25'(quo) * 25'(AS_ENTRIES);
    return AW'(25'(as_num) - back);
  endfunction

  // Each word holds the packet count above the byte count.
  logic [MW-1:0] mem [AS_ENTRIES];
  logic [MW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [MW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  state_e state_q, state_d;
  logic [AW:0]   ctr_q, ctr_d;
  logic          pv_q, pv_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [AW-1:0] s_q, s_d, d_q, d_d;
  logic [LenW-1:0] len_q, len_d;
  logic [MW-1:0] fwd_q, fwd_d;
  logic [SecW-1:0] start_q, start_d;
  logic          open_q, open_d;
  logic [CW-1:0] filled_q, filled_d;
  logic [CW-1:0] em_q, em_d;

  logic [AsW-1:0]  rk_as_q [TOP_COUNT];
  logic [CntW-1:0] rk_by_q [TOP_COUNT];
  logic [CntW-1:0] rk_pk_q [TOP_COUNT];
  logic [TOP_COUNT-1:0] ins;
  logic            rk_we;

  logic            ovalid_q, ovalid_d;
  logic [OutDataW-1:0] odata_q, odata_d;
  logic            ouser_q, ouser_d, olast_q, olast_d;

  logic          in_acc;
  logic [AsW-1:0] in_src, in_dst;
  logic [AW-1:0] in_s, in_d;
  logic [MW-1:0] cur_d;
  logic [CntW-1:0] scan_by;
  logic          out_free;
  logic [TW-1:0] em_idx;

  assign in_src = s_axis_tdata_i[15:0];
  assign in_dst = s_axis_tdata_i[31:16];
  assign in_s   = slot_of(in_src);
  assign in_d   = slot_of(in_dst);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !ovalid_q || m_axis_tready_i;
  assign em_idx = TW'(em_q);
  // The destination read overlaps the source write, so a destination in the same slot takes the new value.
  assign cur_d = (d_q == s_q) ? fwd_q : rdata_q;
  assign scan_by = rdata_q[CntW-1:0];

  // Slot k takes the scanned entry or its upper neighbor when the entry outranks it or the slot is unfilled.
  always_comb begin
    for (int k = 0; k < TOP_COUNT; k++) begin
      ins[k] = (CW'(k) >= filled_q) || (rk_by_q[k] < scan_by);
    end
  end
  assign rk_we = (state_q == ST_SCAN) && pv_q && (scan_by != '0);

  always_ff @(posedge clk_i) begin
    if (rk_we) begin
      for (int k = 0; k < TOP_COUNT; k++) begin
        if (ins[k]) begin
          if (k == 0 || !ins[(k == 0) ? 0 : k - 1]) begin
            rk_as_q[k] <= AsW'(pidx_q);
            rk_by_q[k] <= scan_by;
            rk_pk_q[k] <= rdata_q[MW-1:CntW];
          end else begin
            rk_as_q[k] <= rk_as_q[(k == 0) ? 0 : k - 1];
            rk_by_q[k] <= rk_by_q[(k == 0) ? 0 : k - 1];
            rk_pk_q[k] <= rk_pk_q[(k == 0) ? 0 : k - 1];
          end
        end
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    ctr_d    = ctr_q;
    pv_d     = 1'b0;
    pidx_d   = pidx_q;
    s_d      = s_q;
    d_d      = d_q;
    len_d    = len_q;
    fwd_d    = fwd_q;
    start_d  = start_q;
    open_d   = open_q;
    filled_d = filled_q;
    em_d     = em_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    odata_d  = odata_q;
    ouser_d  = ouser_q;
    olast_d  = olast_q;
    mem_we    = 1'b0;
    mem_waddr = pidx_q;
    mem_wdata = '0;
    mem_raddr = ctr_q[AW-1:0];
    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = ctr_q[AW-1:0];
        ctr_d     = ctr_q + 1'b1;
        if (ctr_q == (AW + 1)'(AS_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        mem_raddr = in_s;
        if (in_acc) begin
          if (s_axis_tuser_i == KindPacket) begin
            s_d   = in_s;
            d_d   = in_d;
            len_d = s_axis_tdata_i[47:32];
            if (!open_q) begin
              open_d  = 1'b1;
              start_d = s_axis_tdata_i[79:48];
            end
            state_d = ST_PKT_S;
          end else begin
            ctr_d    = '0;
            filled_d = '0;
            state_d  = ST_SCAN;
          end
        end
      end
      ST_PKT_S: begin
        mem_we    = 1'b1;
        mem_waddr = s_q;
        mem_wdata = {rdata_q[MW-1:CntW] + CntW'(1),
                     rdata_q[CntW-1:0] + CntW'(len_q)};
        fwd_d     = mem_wdata;
        mem_raddr = d_q;
        state_d   = ST_PKT_D;
      end
      ST_PKT_D: begin
        mem_we    = 1'b1;
        mem_waddr = d_q;
        mem_wdata = {cur_d[MW-1:CntW] + CntW'(1), cur_d[CntW-1:0] + CntW'(len_q)};
        state_d   = ST_IDLE;
      end
      ST_SCAN: begin
        if (ctr_q != (AW + 1)'(AS_ENTRIES)) begin
          pv_d   = 1'b1;
          pidx_d = ctr_q[AW-1:0];
          ctr_d  = ctr_q + 1'b1;
        end
        if (pv_q) begin
          mem_we = 1'b1;
          if (rk_we && filled_q != CW'(TOP_COUNT) && ins[TW'(filled_q)]) begin
            filled_d = filled_q + 1'b1;
          end
        end else if (ctr_q == (AW + 1)'(AS_ENTRIES)) begin
          em_d    = '0;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (filled_q == '0) begin
            odata_d = {CntW'(0), CntW'(0), AsW'(0), start_q};
            ouser_d = 1'b0;
            olast_d = 1'b1;
          end else begin
            odata_d = {rk_pk_q[em_idx], rk_by_q[em_idx], rk_as_q[em_idx], start_q};
            ouser_d = 1'b1;
            olast_d = (em_q + 1'b1 == filled_q);
          end
          em_d = em_q + 1'b1;
          if (filled_q == '0 || em_q + 1'b1 == filled_q) begin
            start_d = '0;
            open_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // This branch grows the filled count when the slot at the filled count does not take the entry, which cannot occur.
    if (state_q == ST_SCAN && rk_we && filled_q != CW'(TOP_COUNT) && !ins[TW'(filled_q)]) begin
      filled_d = filled_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLR;
      ctr_q    <= '0;
      pv_q     <= 1'b0;
      open_q   <= 1'b0;
      start_q  <= '0;
      filled_q <= '0;
      em_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ctr_q    <= ctr_d;
      pv_q     <= pv_d;
      open_q   <= open_d;
      start_q  <= start_d;
      filled_q <= filled_d;
      em_q     <= em_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    s_q     <= s_d;
    d_q     <= d_d;
    len_q   <= len_d;
    fwd_q   <= fwd_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tuser_o  = ouser_q;
  assign m_axis_tlast_o  = olast_q;

endmodule
